FILE: rtl/iqrmq_pkg.sv
// ----------------------------------------------------------------------------
// iqrmq_pkg: shared types, constants and table functions
// Widths of the datapath, register codes, sequencer states and the Q30
// sine series used to build the oscillator and ramp tables at elaboration.
// ----------------------------------------------------------------------------
package iqrmq_pkg;

    // default values of the top-level parameters
    localparam int RAMP_LEN_DEF       = 40;
    localparam int INDEX_BITS_DEF     = 24;
    localparam int PHASE_LUT_BITS_DEF = 10;

    // field and register widths
    localparam int SAMP_W     = 16;
    localparam int OUT_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int PHASE_W    = 32;
    localparam int POS_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // shared multiply-accumulate unit
    localparam int FRAC_BITS = 15;
    localparam int MAC_A_W   = 19;                    // signed sample operand
    localparam int MAC_B_W   = 16;                    // unsigned coefficient
    localparam int MAC_P_W   = MAC_A_W + MAC_B_W + 1;
    localparam int MAC_ACC_W = MAC_P_W + 2;

    localparam logic [MAC_B_W-1:0] UNITY_WEIGHT = MAC_B_W'(1 << FRAC_BITS);

    // register reset values
    localparam logic [GAIN_W-1:0]  LEVEL_GAIN_RST = GAIN_W'(22938);
    localparam logic [PHASE_W-1:0] PHASE_INC_RST  = '0;
    localparam logic [POS_W-1:0]   LIVE_START_RST = POS_W'(20000);
    localparam logic [POS_W-1:0]   LIVE_END_RST   = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEVEL_GAIN,
        CFG_PHASE_INC,
        CFG_LIVE_START,
        CFG_LIVE_END
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GAIN_I,
        S_GAIN_Q,
        S_RAMP_I,
        S_RAMP_Q,
        S_MIX_I0,
        S_MIX_I1,
        S_MIX_Q0,
        S_MIX_Q1,
        S_DONE
    } t_state;

    typedef struct packed {
        logic use_acc;   // add onto the running sum instead of the rounding bias
        logic neg;       // subtract the product
    } t_mac_ctl;

    typedef struct packed {
        logic calc;      // register distances into and out of the live window
        logic pick;      // register the ramp weight
    } t_win_ctl;

    localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Q30 sine of u * (pi/2) / 2^30, u in [0, 2^30]
    function automatic logic [63:0] sin_q30(input logic [63:0] u);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        x  = (u * HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
        return (x * t) >> 30;
    endfunction

    // quarter-wave oscillator entry, Q15 clipped to 32767
    function automatic logic [MAC_B_W-1:0] quarter_val(input logic [63:0] u);
        logic [63:0] r;
        r = (sin_q30(u) + (64'd1 << 14)) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return MAC_B_W'(r);
    endfunction

    // raised-cosine ramp weight, sin^2 in Q15
    function automatic logic [MAC_B_W-1:0] ramp_val(input logic [63:0] u);
        logic [63:0] s;
        s = sin_q30(u);
        return MAC_B_W'((s * s + (64'd1 << 44)) >> 45);
    endfunction

endpackage

FILE: rtl/iq_ramp_mix_quantizer_top.sv
// ----------------------------------------------------------------------------
// iq_ramp_mix_quantizer_top: level, ramp, NCO mix and 8-bit quantizer
// Scales complex Q1.15 samples, ramps the live window edges, rotates by an
// oscillator and rounds to saturated signed 8-bit I/Q.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one complex sample per item: tdata = {q_in, i_in},
//   tuser[0] = frame_start (clears sample index and oscillator phase).
//   m_axis returns one item per input: tdata = {q_out, i_out}, both in
//   -127..127.
//   Registers are written through i_cfg_we / i_cfg_index / i_cfg_data
//   (0 level gain, 1 phase increment, 2 live start, 3 live end); write
//   them only while the block is idle, as the block does not enforce it.
// Sequencing:
//   One multiplier is shared by all steps: gain I/Q, ramp I/Q (unity weight
//   outside the ramp), and four mixer products when the increment is nonzero.
//   An item runs through the gain and ramp steps, then the mixer steps if
//   enabled, before its result is registered. s_axis_tready is high only
//   between items, so a new item is taken only once the last one is done.
//   A finished result sits in the output register; the next item is taken
//   while it waits, and the sequencer holds at its last step until the
//   output register frees up.
// Reset:
//   Synchronous, active low. Registers return to their defaults, the index
//   and phase clear, and the output register empties.
// ----------------------------------------------------------------------------
module iq_ramp_mix_quantizer_top #(
    parameter int RAMP_LEN       = iqrmq_pkg::RAMP_LEN_DEF,
    parameter int INDEX_BITS     = iqrmq_pkg::INDEX_BITS_DEF,
    parameter int PHASE_LUT_BITS = iqrmq_pkg::PHASE_LUT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [31:0]                         s_axis_tdata,  // i_in[15:0], q_in[31:16]
    input  logic [0:0]                          s_axis_tuser,  // frame_start[0]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [15:0]                         m_axis_tdata,  // i_out[7:0], q_out[15:8]
    input  logic                                i_cfg_we,
    input  logic [iqrmq_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [iqrmq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW   = iqrmq_pkg::MAC_A_W;
    localparam int BW   = iqrmq_pkg::MAC_B_W;
    localparam int SW   = iqrmq_pkg::SAMP_W;
    localparam int OW   = iqrmq_pkg::OUT_W;
    localparam int PHW  = iqrmq_pkg::PHASE_W;
    localparam int RA_W = PHASE_LUT_BITS + 1;
    localparam int QW   = AW + OW;
    localparam logic [RA_W-1:0] QUARTER_N = RA_W'(1 << PHASE_LUT_BITS);

    localparam logic signed [QW-1:0] Q_SCALE = QW'(127);
    localparam logic signed [QW-1:0] Q_HALF  = QW'(1 << (iqrmq_pkg::FRAC_BITS - 1));
    localparam logic signed [QW-1:0] Q_MAX   = QW'(127);
    localparam logic signed [QW-1:0] Q_MIN   = -QW'(127);

    // output scaling by 127, rounding and symmetric saturation
    function automatic logic [OW-1:0] quantize(input logic signed [AW-1:0] m);
        logic signed [QW-1:0] sc;
        logic signed [QW-1:0] r;
        sc = QW'(m) * Q_SCALE + Q_HALF;
        r  = sc >>> iqrmq_pkg::FRAC_BITS;
        if (r > Q_MAX) begin
            r = Q_MAX;
        end else if (r < Q_MIN) begin
            r = Q_MIN;
        end
        return r[OW-1:0];
    endfunction

    iqrmq_pkg::t_state   r_state, n_state;
    iqrmq_pkg::t_mac_ctl mac_ctl;
    iqrmq_pkg::t_win_ctl win_ctl;

    logic [iqrmq_pkg::GAIN_W-1:0] r_level_gain;
    logic [PHW-1:0]               r_phase_inc;
    logic [iqrmq_pkg::POS_W-1:0]  r_live_start, r_live_end;
    logic [INDEX_BITS-1:0]        r_index;
    logic [PHW-1:0]               r_phase;

    logic signed [AW-1:0] r_gi, r_gq, r_mi, r_mq;
    logic [BW-1:0]        r_sin_mag;
    logic [OW-1:0]        r_out_i, r_out_q;
    logic                 r_out_valid;

    logic                 in_accept, done_go, mix_en;
    logic signed [AW-1:0] mac_a, mac_res;
    logic [BW-1:0]        mac_b, weight, rom_data;

    logic [1:0]                quad;
    logic [PHASE_LUT_BITS-1:0] lut_idx;
    logic [RA_W-1:0]           idx_e, sin_addr, cos_addr, rom_addr;
    logic                      sin_neg, cos_neg;

    assign s_axis_tready = (r_state == iqrmq_pkg::S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign mix_en        = (r_phase_inc != '0);

    // oscillator phase to quarter-table address and sign;
    // cosine is the sine a quarter turn ahead
    assign quad     = r_phase[PHW-1 -: 2];
    assign lut_idx  = r_phase[PHW-3 -: PHASE_LUT_BITS];
    assign idx_e    = {1'b0, lut_idx};
    assign sin_addr = quad[0] ? (QUARTER_N - idx_e) : idx_e;
    assign cos_addr = quad[0] ? idx_e : (QUARTER_N - idx_e);
    assign sin_neg  = quad[1];
    assign cos_neg  = quad[1] ^ quad[0];

    // sine is fetched during the first gain step, cosine stays on the port after
    assign rom_addr = (r_state == iqrmq_pkg::S_GAIN_I) ? sin_addr : cos_addr;

    iqrmq_sin_rom #(
        .LUT_BITS (PHASE_LUT_BITS)
    ) u_sin_rom (
        .i_clk  (i_clk),
        .i_addr (rom_addr),
        .o_data (rom_data)
    );

    iqrmq_ramp_win #(
        .RAMP_LEN   (RAMP_LEN),
        .INDEX_BITS (INDEX_BITS)
    ) u_ramp_win (
        .i_clk        (i_clk),
        .i_ctl        (win_ctl),
        .i_index      (r_index),
        .i_live_start (r_live_start),
        .i_live_end   (r_live_end),
        .o_weight     (weight)
    );

    iqrmq_mac u_mac (
        .i_clk (i_clk),
        .i_ctl (mac_ctl),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_res (mac_res)
    );

    // sequencer: next state and shared-unit operand selection
    always_comb begin
        n_state = r_state;
        mac_ctl = '0;
        mac_a   = r_gi;
        mac_b   = r_level_gain;
        win_ctl = '0;
        done_go = 1'b0;
        unique case (r_state)
            iqrmq_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = iqrmq_pkg::S_GAIN_I;
                end
            end
            iqrmq_pkg::S_GAIN_I: begin
                win_ctl.calc = 1'b1;
                n_state      = iqrmq_pkg::S_GAIN_Q;
            end
            iqrmq_pkg::S_GAIN_Q: begin
                mac_a        = r_gq;
                win_ctl.pick = 1'b1;
                n_state      = iqrmq_pkg::S_RAMP_I;
            end
            iqrmq_pkg::S_RAMP_I: begin
                mac_b   = weight;
                n_state = iqrmq_pkg::S_RAMP_Q;
            end
            iqrmq_pkg::S_RAMP_Q: begin
                mac_a   = r_gq;
                mac_b   = weight;
                n_state = mix_en ? iqrmq_pkg::S_MIX_I0 : iqrmq_pkg::S_DONE;
            end
            iqrmq_pkg::S_MIX_I0: begin
                // -gq * sin
                mac_a       = r_gq;
                mac_b       = r_sin_mag;
                mac_ctl.neg = ~sin_neg;
                n_state     = iqrmq_pkg::S_MIX_I1;
            end
            iqrmq_pkg::S_MIX_I1: begin
                // + gi * cos
                mac_b           = rom_data;
                mac_ctl.use_acc = 1'b1;
                mac_ctl.neg     = cos_neg;
                n_state         = iqrmq_pkg::S_MIX_Q0;
            end
            iqrmq_pkg::S_MIX_Q0: begin
                // gi * sin
                mac_b       = r_sin_mag;
                mac_ctl.neg = sin_neg;
                n_state     = iqrmq_pkg::S_MIX_Q1;
            end
            iqrmq_pkg::S_MIX_Q1: begin
                // + gq * cos
                mac_a           = r_gq;
                mac_b           = rom_data;
                mac_ctl.use_acc = 1'b1;
                mac_ctl.neg     = cos_neg;
                n_state         = iqrmq_pkg::S_DONE;
            end
            iqrmq_pkg::S_DONE: begin
                done_go = !r_out_valid || m_axis_tready;
                if (done_go) begin
                    n_state = iqrmq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = iqrmq_pkg::S_IDLE;
            end
        endcase
    end

    // control state, registers, index and phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= iqrmq_pkg::S_IDLE;
            r_level_gain <= iqrmq_pkg::LEVEL_GAIN_RST;
            r_phase_inc  <= iqrmq_pkg::PHASE_INC_RST;
            r_live_start <= iqrmq_pkg::LIVE_START_RST;
            r_live_end   <= iqrmq_pkg::LIVE_END_RST;
            r_index      <= '0;
            r_phase      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (iqrmq_pkg::t_cfg_reg'(i_cfg_index))
                    iqrmq_pkg::CFG_LEVEL_GAIN: r_level_gain <= i_cfg_data[iqrmq_pkg::GAIN_W-1:0];
                    iqrmq_pkg::CFG_PHASE_INC:  r_phase_inc  <= i_cfg_data[PHW-1:0];
                    iqrmq_pkg::CFG_LIVE_START: r_live_start <= i_cfg_data[iqrmq_pkg::POS_W-1:0];
                    iqrmq_pkg::CFG_LIVE_END:   r_live_end   <= i_cfg_data[iqrmq_pkg::POS_W-1:0];
                endcase
            end
            if (in_accept) begin
                if (s_axis_tuser[0]) begin
                    r_index <= '0;
                    r_phase <= '0;
                end
            end else if (done_go) begin
                r_phase <= r_phase + r_phase_inc;
                if (r_index != '1) begin
                    r_index <= r_index + 1'b1;
                end
            end
            if (done_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sample datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            iqrmq_pkg::S_IDLE: begin
                if (in_accept) begin
                    r_gi <= AW'($signed(s_axis_tdata[SW-1:0]));
                    r_gq <= AW'($signed(s_axis_tdata[2*SW-1:SW]));
                end
            end
            iqrmq_pkg::S_GAIN_I, iqrmq_pkg::S_RAMP_I: begin
                r_gi <= mac_res;
            end
            iqrmq_pkg::S_GAIN_Q: begin
                r_gq      <= mac_res;
                r_sin_mag <= rom_data;
            end
            iqrmq_pkg::S_RAMP_Q: begin
                r_gq <= mac_res;
            end
            iqrmq_pkg::S_MIX_I1: begin
                r_mi <= mac_res;
            end
            iqrmq_pkg::S_MIX_Q1: begin
                r_mq <= mac_res;
            end
            default: begin
            end
        endcase
        if (done_go) begin
            r_out_i <= quantize(mix_en ? r_mi : r_gi);
            r_out_q <= quantize(mix_en ? r_mq : r_gq);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_q, r_out_i};

    // mixer steps never run with the oscillator bypassed
    a_mix_only_when_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iqrmq_pkg::S_MIX_I0 || r_state == iqrmq_pkg::S_MIX_I1 ||
         r_state == iqrmq_pkg::S_MIX_Q0 || r_state == iqrmq_pkg::S_MIX_Q1) |-> mix_en)
        else $error("mixer step with zero phase increment");

    // saturation keeps codes symmetric
    a_out_symmetric: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_i != 8'h80 && r_out_q != 8'h80))
        else $error("output code -128");

    // phase holds when bypassed
    a_phase_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done_go && !mix_en) |=> (r_phase == $past(r_phase)))
        else $error("phase moved with zero increment");

    // index steps by one per finished item until it saturates
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done_go && r_index != '1) |=> (r_index == $past(r_index) + 1'b1))
        else $error("sample index did not advance");

endmodule

FILE: rtl/iqrmq_sin_rom.sv
// ----------------------------------------------------------------------------
// iqrmq_sin_rom: quarter-wave sine table
// Registered-read ROM of 2^LUT_BITS + 1 Q15 entries covering 0..pi/2.
// ----------------------------------------------------------------------------
module iqrmq_sin_rom #(
    parameter int LUT_BITS = iqrmq_pkg::PHASE_LUT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic [LUT_BITS:0]               i_addr,
    output logic [iqrmq_pkg::MAC_B_W-1:0]   o_data
);

    localparam int DEPTH = (1 << LUT_BITS) + 1;

    typedef logic [iqrmq_pkg::MAC_B_W-1:0] t_rom [DEPTH];

    function automatic t_rom build_rom();
        t_rom tab;
        for (int j = 0; j < DEPTH; j++) begin
            tab[j] = iqrmq_pkg::quarter_val(64'(j) << (30 - LUT_BITS));
        end
        return tab;
    endfunction

    localparam t_rom ROM = build_rom();

    logic [iqrmq_pkg::MAC_B_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= ROM[i_addr];
    end

    assign o_data = r_data;

endmodule

FILE: rtl/iqrmq_ramp_win.sv
// ----------------------------------------------------------------------------
// iqrmq_ramp_win: live-window test and ramp weight
// Two steps: distances from both window edges, then the nearer edge picks
// a raised-cosine weight, or unity when outside the ramp.
// ----------------------------------------------------------------------------
module iqrmq_ramp_win #(
    parameter int RAMP_LEN   = iqrmq_pkg::RAMP_LEN_DEF,
    parameter int INDEX_BITS = iqrmq_pkg::INDEX_BITS_DEF
) (
    input  logic                            i_clk,
    input  iqrmq_pkg::t_win_ctl             i_ctl,
    input  logic [INDEX_BITS-1:0]           i_index,
    input  logic [iqrmq_pkg::POS_W-1:0]     i_live_start,
    input  logic [iqrmq_pkg::POS_W-1:0]     i_live_end,
    output logic [iqrmq_pkg::MAC_B_W-1:0]   o_weight
);

    localparam int IW = ((INDEX_BITS > iqrmq_pkg::POS_W) ? INDEX_BITS : iqrmq_pkg::POS_W) + 1;
    localparam int KW = (RAMP_LEN > 1) ? $clog2(RAMP_LEN) : 1;
    localparam int TAB_DEPTH = 1 << KW;

    typedef logic [iqrmq_pkg::MAC_B_W-1:0] t_wtab [TAB_DEPTH];

    function automatic t_wtab build_wtab();
        t_wtab       tab;
        logic [63:0] u;
        for (int k = 0; k < TAB_DEPTH; k++) begin
            if (k < RAMP_LEN) begin
                u      = (64'(2 * k + 1) << 29) / 64'(RAMP_LEN);
                tab[k] = iqrmq_pkg::ramp_val(u);
            end else begin
                tab[k] = '0;
            end
        end
        return tab;
    endfunction

    localparam t_wtab WTAB = build_wtab();
    localparam logic [IW-1:0] RAMP_LEN_W = IW'(RAMP_LEN);

    logic [IW-1:0] n_e, ls_e, le_e;
    logic [IW-1:0] into_d, from_d;
    logic [IW-1:0] r_into, r_from;
    logic          r_inwin;
    logic          a_le_b, lt_a, lt_b;
    logic [iqrmq_pkg::MAC_B_W-1:0] n_weight, r_weight;

    assign n_e  = IW'(i_index);
    assign ls_e = IW'(i_live_start);
    assign le_e = IW'(i_live_end);

    // n - start, and end - 1 - n as end + ~n; sign bits give the window test
    assign into_d = n_e - ls_e;
    assign from_d = le_e + ~n_e;

    always_comb begin
        a_le_b = (r_into <= r_from);
        lt_a   = (r_into < RAMP_LEN_W);
        lt_b   = (r_from < RAMP_LEN_W);
        if (r_inwin && (a_le_b ? lt_a : lt_b)) begin
            n_weight = a_le_b ? WTAB[r_into[KW-1:0]] : WTAB[r_from[KW-1:0]];
        end else begin
            n_weight = iqrmq_pkg::UNITY_WEIGHT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.calc) begin
            r_into  <= into_d;
            r_from  <= from_d;
            r_inwin <= !into_d[IW-1] && !from_d[IW-1];
        end
        if (i_ctl.pick) begin
            r_weight <= n_weight;
        end
    end

    assign o_weight = r_weight;

endmodule

FILE: rtl/iqrmq_mac.sv
// ----------------------------------------------------------------------------
// iqrmq_mac: shared multiply-accumulate unit
// Signed sample times unsigned Q15 coefficient, added to or subtracted from
// the rounding bias or the running sum; result is the sum shifted by 15.
// ----------------------------------------------------------------------------
module iqrmq_mac (
    input  logic                                   i_clk,
    input  iqrmq_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [iqrmq_pkg::MAC_A_W-1:0]   i_a,
    input  logic        [iqrmq_pkg::MAC_B_W-1:0]   i_b,
    output logic signed [iqrmq_pkg::MAC_A_W-1:0]   o_res
);

    localparam int AW = iqrmq_pkg::MAC_A_W;
    localparam int PW = iqrmq_pkg::MAC_P_W;
    localparam int SW = iqrmq_pkg::MAC_ACC_W;
    localparam int FB = iqrmq_pkg::FRAC_BITS;
    localparam logic signed [SW-1:0] ROUND_BIAS = SW'(1 << (FB - 1));

    logic signed [PW-1:0] prod;
    logic signed [SW-1:0] base, sum, r_acc;

    assign prod = i_a * $signed({1'b0, i_b});
    assign base = i_ctl.use_acc ? r_acc : ROUND_BIAS;
    assign sum  = i_ctl.neg ? (base - SW'(prod)) : (base + SW'(prod));

    always_ff @(posedge i_clk) begin
        r_acc <= sum;
    end

    // floor of sum / 2^15, rounding bias already included
    assign o_res = sum[FB+AW-1:FB];

endmodule

FILE: test/iq_ramp_mix_quantizer_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// iq_ramp_mix_quantizer_top_tb: self-checking bench for the I/Q quantizer
// Streams complex Q1.15 samples through the block under random stall patterns
// on both sides. A scoreboard rebuilds the gain, edge ramp, oscillator and
// 8-bit rounding per sample and checks every returned I/Q code in order.
// ----------------------------------------------------------------------------

// one output item, laid out as on m_axis_tdata
typedef struct packed {
    logic signed [iqrmq_pkg::OUT_W-1:0] q;
    logic signed [iqrmq_pkg::OUT_W-1:0] i;
} t_dac_pair;

class iq_dac_scoreboard;
    int     quarter_wave[(1 << iqrmq_pkg::PHASE_LUT_BITS_DEF) + 1];
    longint edge_weight[iqrmq_pkg::RAMP_LEN_DEF];

    logic [iqrmq_pkg::GAIN_W-1:0]         level_gain;
    logic [iqrmq_pkg::PHASE_W-1:0]        phase_step;
    logic [iqrmq_pkg::POS_W-1:0]          live_start;
    logic [iqrmq_pkg::POS_W-1:0]          live_end;
    logic [iqrmq_pkg::INDEX_BITS_DEF-1:0] sample_pos;
    logic [iqrmq_pkg::PHASE_W-1:0]        nco_phase;

    t_dac_pair pending_codes[$];
    int samples_in, codes_checked, failures, ramped, mixed, clipped;

    function new();
        longint unsigned s;
        longint unsigned u;
        int j;
        for (j = 0; j <= (1 << iqrmq_pkg::PHASE_LUT_BITS_DEF); j++) begin
            s = (q30_sine(longint'(j) << (30 - iqrmq_pkg::PHASE_LUT_BITS_DEF))
                 + (64'd1 << 14)) >> 15;
            quarter_wave[j] = (s > 64'd32767) ? 32767 : int'(s);
        end
        for (j = 0; j < iqrmq_pkg::RAMP_LEN_DEF; j++) begin
            u = (longint'(2 * j + 1) << 29) / iqrmq_pkg::RAMP_LEN_DEF;
            s = q30_sine(u);
            edge_weight[j] = longint'((s * s + (64'd1 << 44)) >> 45);
        end
        level_gain = iqrmq_pkg::LEVEL_GAIN_RST;
        phase_step = iqrmq_pkg::PHASE_INC_RST;
        live_start = iqrmq_pkg::LIVE_START_RST;
        live_end   = iqrmq_pkg::LIVE_END_RST;
        sample_pos = '0;
        nco_phase  = '0;
        samples_in = 0;
        codes_checked = 0;
        failures = 0;
        ramped = 0;
        mixed = 0;
        clipped = 0;
    endfunction

    // Q30 sine of u quarter turns / 2^30 by a truncated Horner series
    function longint unsigned q30_sine(longint unsigned u);
        longint unsigned x, x2, t;
        longint unsigned divs[5];
        divs = '{110, 72, 42, 20, 6};
        x  = (u * iqrmq_pkg::HALF_PI_Q30) >> 30;
        x2 = (x * x) >> 30;
        t  = iqrmq_pkg::Q30_ONE;
        for (int k = 0; k < 5; k++) begin
            t = iqrmq_pkg::Q30_ONE - ((x2 * t) >> 30) / divs[k];
        end
        return (x * t) >> 30;
    endfunction

    // round half up, i.e. floor((v + half) / 2^s)
    function longint round_shift(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function longint nco_sine(logic [iqrmq_pkg::PHASE_W-1:0] p);
        logic [1:0] quad;
        int idx;
        longint v;
        quad = p[31:30];
        idx  = p[29 -: iqrmq_pkg::PHASE_LUT_BITS_DEF];
        v = quad[0] ? quarter_wave[(1 << iqrmq_pkg::PHASE_LUT_BITS_DEF) - idx]
                    : quarter_wave[idx];
        return quad[1] ? -v : v;
    endfunction

    function logic [iqrmq_pkg::OUT_W-1:0] to_dac_code(longint m);
        longint r;
        r = round_shift(m * 127, iqrmq_pkg::FRAC_BITS);
        if (r > 127) begin
            r = 127;
            clipped++;
        end else if (r < -127) begin
            r = -127;
            clipped++;
        end
        return r[iqrmq_pkg::OUT_W-1:0];
    endfunction

    function void set_reg(iqrmq_pkg::t_cfg_reg idx, logic [iqrmq_pkg::CFG_DATA_W-1:0] word);
        case (idx)
            iqrmq_pkg::CFG_LEVEL_GAIN: level_gain = word[iqrmq_pkg::GAIN_W-1:0];
            iqrmq_pkg::CFG_PHASE_INC:  phase_step = word[iqrmq_pkg::PHASE_W-1:0];
            iqrmq_pkg::CFG_LIVE_START: live_start = word[iqrmq_pkg::POS_W-1:0];
            iqrmq_pkg::CFG_LIVE_END:   live_end   = word[iqrmq_pkg::POS_W-1:0];
            default: ;
        endcase
    endfunction

    // accepted input item: advance the model state and queue its codes
    function void note_sample(logic signed [iqrmq_pkg::SAMP_W-1:0] si,
                              logic signed [iqrmq_pkg::SAMP_W-1:0] sq,
                              logic fs);
        longint gi, gq, mi, mq, s, c;
        longint unsigned into, left_to_end, k;
        t_dac_pair codes;
        if (fs) begin
            sample_pos = '0;
            nco_phase  = '0;
        end
        gi = round_shift(longint'(si) * longint'(level_gain), iqrmq_pkg::FRAC_BITS);
        gq = round_shift(longint'(sq) * longint'(level_gain), iqrmq_pkg::FRAC_BITS);
        if (sample_pos >= live_start && sample_pos < live_end) begin
            into        = sample_pos - live_start;
            left_to_end = live_end - 1 - sample_pos;
            k = (into < left_to_end) ? into : left_to_end;
            if (k < iqrmq_pkg::RAMP_LEN_DEF) begin
                gi = round_shift(gi * edge_weight[k], iqrmq_pkg::FRAC_BITS);
                gq = round_shift(gq * edge_weight[k], iqrmq_pkg::FRAC_BITS);
                ramped++;
            end
        end
        if (phase_step != '0) begin
            s  = nco_sine(nco_phase);
            c  = nco_sine(nco_phase + 32'h4000_0000);
            mi = round_shift(gi * c - gq * s, iqrmq_pkg::FRAC_BITS);
            mq = round_shift(gi * s + gq * c, iqrmq_pkg::FRAC_BITS);
            nco_phase = nco_phase + phase_step;
            mixed++;
        end else begin
            mi = gi;
            mq = gq;
        end
        codes.i = to_dac_code(mi);
        codes.q = to_dac_code(mq);
        pending_codes.insert(pending_codes.size(), codes);
        if (sample_pos != '1) begin
            sample_pos++;
        end
        samples_in++;
    endfunction

    function void check_codes(logic [2*iqrmq_pkg::OUT_W-1:0] word);
        t_dac_pair got, want;
        got = word;
        if (pending_codes.size() == 0) begin
            $display("%0t: result with nothing pending: i=%0d q=%0d", $time, got.i, got.q);
            failures++;
            return;
        end
        want = pending_codes.pop_front();
        if (got.i !== want.i) begin
            $display("%0t: i_out mismatch: expected %0d actual %0d", $time, want.i, got.i);
            failures++;
        end
        if (got.q !== want.q) begin
            $display("%0t: q_out mismatch: expected %0d actual %0d", $time, want.q, got.q);
            failures++;
        end
        codes_checked++;
    endfunction
endclass

module iq_ramp_mix_quantizer_top_tb;

    // every input starts at a known value
    logic                                  i_clk         = 1'b0;
    logic                                  i_rst_n       = 1'b0;
    logic                                  s_axis_tvalid = 1'b0;
    logic [31:0]                           s_axis_tdata  = '0;   // i_in[15:0], q_in[31:16]
    logic [0:0]                            s_axis_tuser  = '0;   // frame_start[0]
    logic                                  m_axis_tready = 1'b0;
    logic                                  i_cfg_we      = 1'b0;
    iqrmq_pkg::t_cfg_reg                   i_cfg_index   = iqrmq_pkg::CFG_LEVEL_GAIN;
    logic [iqrmq_pkg::CFG_DATA_W-1:0]      i_cfg_data    = '0;

    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [15:0] m_axis_tdata;                   // i_out[7:0], q_out[15:8]

    // stall controls: percentages of idle cycles per side, plus a long
    // receiver hold-off counted down by the receiver process itself
    int src_idle_pct = 0;
    int rx_idle_pct  = 0;
    int rx_hold_left = 0;

    iq_dac_scoreboard sb;

    iq_ramp_mix_quantizer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // 20 ns clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // hard stop; far beyond the slowest legal run (up to 1400 items plus
    // random stalls on both sides)
    initial begin
        #10_000_000;
        $display("iq_ramp_mix_quantizer_top_tb NOT OK");
        $finish;
    end

    // receiver: ready changes on the falling edge only
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left  <= rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // results are taken at the rising edge, before the design updates
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_codes(m_axis_tdata);
        end
    end

    // offer one item, with random idle cycles ahead of it; returns right
    // after the edge that accepted it, with tvalid still high
    task automatic send_sample(input logic [15:0] si, input logic [15:0] sq, input logic fs);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sq, si};
        s_axis_tuser  <= fs;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(si, sq, fs);
    endtask

    task automatic pause_sender();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // all results home, then a margin past the mixer steps
    task automatic wait_idle();
        while (sb.pending_codes.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_reg(input iqrmq_pkg::t_cfg_reg idx,
                             input logic [iqrmq_pkg::CFG_DATA_W-1:0] word);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= word;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_reg(idx, word);
    endtask

    // full-scale corners, small values around zero, or anything
    function automatic logic [15:0] random_sample();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'($urandom_range(128)) - 16'd64;
            default: return 16'($urandom());
        endcase
    endfunction

    initial begin
        int phase, remaining, frame_len, j;
        logic [31:0] gain_w, step_w, start_w, end_w;

        sb = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        src_idle_pct = 34;
        rx_idle_pct  = 53;

        // reset settings: mixer bypassed, live window empty
        send_sample(16'h0000, 16'h0000, 1'b1);
        send_sample(16'h7FFF, 16'h8000, 1'b0);
        send_sample(16'h8000, 16'h7FFF, 1'b0);
        send_sample(16'hFFFF, 16'h0001, 1'b0);
        send_sample(16'h0001, 16'hFFFF, 1'b0);
        send_sample(16'h5555, 16'hAAAA, 1'b0);
        pause_sender();
        wait_idle();

        // gain past full scale (clips), 3/8-turn step so the phase wraps
        // every few items, short window where both ramps overlap
        write_reg(iqrmq_pkg::CFG_LEVEL_GAIN, 32'd65535);
        write_reg(iqrmq_pkg::CFG_PHASE_INC, 32'h6000_0000);
        write_reg(iqrmq_pkg::CFG_LIVE_START, 32'd2);
        write_reg(iqrmq_pkg::CFG_LIVE_END, 32'd12);
        for (j = 0; j < 14; j++) begin
            send_sample(random_sample(), random_sample(), j == 0);
        end
        pause_sender();
        wait_idle();

        // random part: each phase a new register set, then framed traffic
        for (phase = 0; phase < 12; phase++) begin
            src_idle_pct = (phase < 4) ? 34 : (phase < 8) ? 53 : 0;
            rx_idle_pct  = (phase < 4) ? 53 : (phase < 8) ? 34 : 0;
            case (phase)
                0: begin
                    gain_w  = 32'd32768;
                    step_w  = 32'hFFFF_FFFF;
                    start_w = '0;
                    end_w   = 32'hFF_FFFF;
                end
                1: begin
                    gain_w  = '0;
                    step_w  = 32'd1;
                    start_w = 32'hFF_FFFF;
                    end_w   = 32'hFF_FFFF;
                end
                default: begin
                    case ($urandom_range(9))
                        0: gain_w = 32'd65535;
                        1: gain_w = 32'd32768;
                        default: gain_w = $urandom_range(32768);
                    endcase
                    case ($urandom_range(7))
                        0, 1: step_w = '0;
                        2: step_w = 32'h8000_0000;
                        3: step_w = $urandom_range(255);
                        default: step_w = $urandom();
                    endcase
                    case ($urandom_range(9))
                        0: start_w = '0;
                        1: start_w = 32'hFF_FFFF;
                        default: start_w = $urandom_range(60);
                    endcase
                    // mostly a window that fits inside a frame; else empty,
                    // inverted or open to the end of the index range
                    case ($urandom_range(9))
                        0: end_w = '0;
                        1: end_w = 32'hFF_FFFF;
                        2, 3: end_w = $urandom_range(start_w);
                        default: end_w = (start_w + $urandom_range(200, 1)) & 32'hFF_FFFF;
                    endcase
                    // bits above each register's width must be ignored
                    if ($urandom_range(1)) begin
                        gain_w  |= $urandom() & 32'hFFFF_0000;
                        start_w |= $urandom() & 32'hFF00_0000;
                        end_w   |= $urandom() & 32'hFF00_0000;
                    end
                end
            endcase
            write_reg(iqrmq_pkg::CFG_LEVEL_GAIN, gain_w);
            write_reg(iqrmq_pkg::CFG_PHASE_INC, step_w);
            write_reg(iqrmq_pkg::CFG_LIVE_START, start_w);
            write_reg(iqrmq_pkg::CFG_LIVE_END, end_w);

            // long output stall while input keeps coming: fills the
            // output register and the sequencer, so tready must drop
            if (phase == 8) begin
                rx_hold_left = 200;
            end

            remaining = $urandom_range(115, 90);
            while (remaining > 0) begin
                case ($urandom_range(19))
                    0, 1: frame_len = $urandom_range(3, 1);
                    2, 3, 4: frame_len = $urandom_range(400, 200);
                    default: frame_len = $urandom_range(150, 20);
                endcase
                // frame restarts now and then land mid-frame
                for (j = 0; j < frame_len && remaining > 0; j++) begin
                    send_sample(random_sample(), random_sample(),
                                (j == 0) || ($urandom_range(99) < 2));
                    remaining--;
                end
            end
            pause_sender();
            wait_idle();
        end

        $display("Ran %0d samples over 14 register settings: %0d ramped, %0d rotated,",
                 sb.samples_in, sb.ramped, sb.mixed);
        $display("%0d codes clipped; compared %0d I/Q results, %0d field failures.",
                 sb.clipped, sb.codes_checked, sb.failures);
        if (sb.failures == 0 && sb.pending_codes.size() == 0) begin
            $display("iq_ramp_mix_quantizer_top_tb OK");
        end else begin
            $display("iq_ramp_mix_quantizer_top_tb NOT OK");
        end
        $finish;
    end

endmodule
